// ===== hdl/ws2812s_pkg.sv =====
package ws2812s_pkg;

   localparam int COLOR_W     = 24;
   localparam int INDEX_W     = 7;
   localparam int WORD_W      = 16;
   localparam int BIT_CNT_W   = 5;
   localparam int CSR_INDEX_W = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   // position of the top color bit, sent first (msb goes first)
   localparam logic [BIT_CNT_W-1:0] LAST_BIT = 5'd23;

   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_START = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THIRD_START  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_PERIOD   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_PERIOD = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_COMPARE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_COMPARE  = 3'd5;

   localparam logic [INDEX_W-1:0] RST_SECOND_START = 7'd27;
   localparam logic [INDEX_W-1:0] RST_THIRD_START  = 7'd55;
   localparam logic [WORD_W-1:0]  RST_BIT_PERIOD   = 16'd95;
   localparam logic [WORD_W-1:0]  RST_RESET_PERIOD = 16'd1199;
   localparam logic [WORD_W-1:0]  RST_ZERO_COMPARE = 16'd4;
   localparam logic [WORD_W-1:0]  RST_ONE_COMPARE  = 16'd9;

   typedef enum logic [0:0] {
      KIND_WRITE = 1'b0,
      KIND_TICK  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      CH_FIRST  = 2'd0,
      CH_SECOND = 2'd1,
      CH_THIRD  = 2'd2
   } chan_type;

   typedef struct packed {
      logic [INDEX_W-1:0] second_start;
      logic [INDEX_W-1:0] third_start;
      logic [WORD_W-1:0]  bit_period;
      logic [WORD_W-1:0]  reset_period;
      logic [WORD_W-1:0]  zero_compare;
      logic [WORD_W-1:0]  one_compare;
   } cfg_type;

   typedef struct packed {
      kind_type           kind;
      logic               store;
      chan_type           chan;
      logic [INDEX_W-1:0] offset;
      logic [COLOR_W-1:0] color;
   } word_type;

   typedef struct packed {
      logic     valid;
      word_type word;
   } head_type;

endpackage

// ===== hdl/ws2812s_front.sv =====
module ws2812s_front #(
   parameter int LEDS_PER_CHANNEL = 32
) (
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_kind,
   input  logic [ws2812s_pkg::INDEX_W-1:0]        req_led_index,
   input  logic [ws2812s_pkg::COLOR_W-1:0]        req_color,
   input  ws2812s_pkg::cfg_type                   cfg,
   input  logic                                   queue_full,
   input  logic                                   clearing,
   output logic                                   push,
   output ws2812s_pkg::word_type                  push_word
);

   localparam int CNT_W = $clog2(LEDS_PER_CHANNEL + 1);
   localparam int CMP_W = (CNT_W > ws2812s_pkg::INDEX_W) ? CNT_W : ws2812s_pkg::INDEX_W;
   localparam logic [CMP_W-1:0] DEPTH = CMP_W'(LEDS_PER_CHANNEL);

   ws2812s_pkg::chan_type               chan;
   logic [ws2812s_pkg::INDEX_W-1:0]     offset;
   logic                                in_range;
   ws2812s_pkg::kind_type               kind;

   // boundaries are tested in order, so the offset never goes negative
   always_comb begin
      chan   = ws2812s_pkg::CH_FIRST;
      offset = req_led_index;
      if (req_led_index < cfg.second_start) begin
         chan   = ws2812s_pkg::CH_FIRST;
         offset = req_led_index;
      end else if (req_led_index < cfg.third_start) begin
         chan   = ws2812s_pkg::CH_SECOND;
         offset = req_led_index - cfg.second_start;
      end else begin
         chan   = ws2812s_pkg::CH_THIRD;
         offset = req_led_index - cfg.third_start;
      end
   end

   assign in_range  = CMP_W'(offset) < DEPTH;
   assign kind      = ws2812s_pkg::kind_type'(req_kind);

   assign req_stall = queue_full || clearing;
   assign push      = req_valid && !req_stall;

   assign push_word.kind   = kind;
   assign push_word.store  = (kind == ws2812s_pkg::KIND_WRITE) && in_range;
   assign push_word.chan   = chan;
   assign push_word.offset = offset;
   assign push_word.color  = req_color;

endmodule

// ===== hdl/ws2812s_queue.sv =====
module ws2812s_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ws2812s_pkg::word_type push_word,
   output logic                  full,
   output ws2812s_pkg::head_type head,
   input  logic                  pop
);

   localparam logic [ws2812s_pkg::QPTR_W:0] DEPTH =
      (ws2812s_pkg::QPTR_W + 1)'(ws2812s_pkg::QUEUE_DEPTH);

   ws2812s_pkg::word_type entry_ff [ws2812s_pkg::QUEUE_DEPTH];

   logic [ws2812s_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ws2812s_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ws2812s_pkg::QPTR_W:0]   count_ff, count_in;
   logic                           do_push, do_pop;

   assign full       = count_ff == DEPTH;
   assign head.valid = count_ff != '0;
   assign head.word  = entry_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ===== hdl/ws2812s_back.sv =====
module ws2812s_back #(
   parameter int LEDS_PER_CHANNEL = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ws2812s_pkg::cfg_type               cfg,
   input  ws2812s_pkg::head_type              head,
   output logic                               pop,
   output logic                               clearing,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ws2812s_pkg::WORD_W-1:0]     rsp_period,
   output logic [ws2812s_pkg::WORD_W-1:0]     rsp_compare_first,
   output logic [ws2812s_pkg::WORD_W-1:0]     rsp_compare_second,
   output logic [ws2812s_pkg::WORD_W-1:0]     rsp_compare_third,
   output logic                               rsp_reset_slot
);

   localparam int ADDR_W = (LEDS_PER_CHANNEL > 1) ? $clog2(LEDS_PER_CHANNEL) : 1;
   localparam int CNT_W  = $clog2(LEDS_PER_CHANNEL + 1);
   localparam logic [CNT_W-1:0]  FRAME_END = CNT_W'(LEDS_PER_CHANNEL);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(LEDS_PER_CHANNEL - 1);

   localparam int COLOR_W = ws2812s_pkg::COLOR_W;
   localparam int WORD_W  = ws2812s_pkg::WORD_W;
   localparam int BIT_W   = ws2812s_pkg::BIT_CNT_W;

   logic [COLOR_W-1:0] store_first  [LEDS_PER_CHANNEL];
   logic [COLOR_W-1:0] store_second [LEDS_PER_CHANNEL];
   logic [COLOR_W-1:0] store_third  [LEDS_PER_CHANNEL];

   logic [COLOR_W-1:0] rd_first_ff, rd_second_ff, rd_third_ff;

   logic               clear_busy_ff, clear_busy_in;
   logic [ADDR_W-1:0]  clear_addr_ff, clear_addr_in;
   logic [CNT_W-1:0]   led_cnt_ff, led_cnt_in;
   logic [BIT_W-1:0]   bit_cnt_ff, bit_cnt_in;

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_reset_ff;
   logic [BIT_W-1:0]   s1_bit_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_period_ff, rsp_first_ff, rsp_second_ff, rsp_third_ff;
   logic               rsp_reset_ff;

   logic               s1_adv, s1_free, head_is_tick, issue_tick, issue_write;
   logic               end_of_frame, rd_en;
   logic [ADDR_W-1:0]  rd_addr, wr_addr;
   logic [COLOR_W-1:0] wr_data;
   logic [2:0]         wr_en;
   logic [BIT_W-1:0]   bit_pos;

   assign clearing = clear_busy_ff;

   assign s1_adv       = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign s1_free      = !s1_valid_ff || s1_adv;
   assign head_is_tick = head.word.kind == ws2812s_pkg::KIND_TICK;
   // a tick waits for room in the read stage, a write never waits on it
   assign pop          = head.valid && !clear_busy_ff && (!head_is_tick || s1_free);
   assign issue_tick   = pop && head_is_tick;
   assign issue_write  = pop && !head_is_tick && head.word.store;
   assign end_of_frame = led_cnt_ff == FRAME_END;

   assign rd_en   = issue_tick && !end_of_frame;
   assign rd_addr = led_cnt_ff[ADDR_W-1:0];
   assign wr_addr = clear_busy_ff ? clear_addr_ff : ADDR_W'(head.word.offset);
   assign wr_data = clear_busy_ff ? '0 : head.word.color;

   always_comb begin
      wr_en = {3{clear_busy_ff}};
      if (issue_write) begin
         case (head.word.chan)
            ws2812s_pkg::CH_FIRST:  wr_en = 3'b001;
            ws2812s_pkg::CH_SECOND: wr_en = 3'b010;
            ws2812s_pkg::CH_THIRD:  wr_en = 3'b100;
            default:                wr_en = 3'b000;
         endcase
      end
   end

   // clearing pass after reset, one row of all three stores per cycle
   always_comb begin
      clear_busy_in = clear_busy_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_busy_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == LAST_ADDR) begin
            clear_busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      led_cnt_in = led_cnt_ff;
      bit_cnt_in = bit_cnt_ff;
      if (issue_tick) begin
         if (end_of_frame) begin
            led_cnt_in = '0;
            bit_cnt_in = '0;
         end else if (bit_cnt_ff == ws2812s_pkg::LAST_BIT) begin
            led_cnt_in = led_cnt_ff + 1'b1;
            bit_cnt_in = '0;
         end else begin
            bit_cnt_in = bit_cnt_ff + 1'b1;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (issue_tick) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
         led_cnt_ff    <= '0;
         bit_cnt_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clear_addr_ff <= clear_addr_in;
         led_cnt_ff    <= led_cnt_in;
         bit_cnt_ff    <= bit_cnt_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en[0]) begin
         store_first[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_first_ff <= store_first[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en[1]) begin
         store_second[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_second_ff <= store_second[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en[2]) begin
         store_third[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_third_ff <= store_third[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (issue_tick) begin
         s1_reset_ff <= end_of_frame;
         s1_bit_ff   <= bit_cnt_ff;
      end
   end

   // msb first
   assign bit_pos = ws2812s_pkg::LAST_BIT - s1_bit_ff;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_reset_ff <= s1_reset_ff;
         if (s1_reset_ff) begin
            rsp_period_ff <= cfg.reset_period;
            rsp_first_ff  <= '0;
            rsp_second_ff <= '0;
            rsp_third_ff  <= '0;
         end else begin
            rsp_period_ff <= cfg.bit_period;
            rsp_first_ff  <= rd_first_ff[bit_pos] ? cfg.one_compare : cfg.zero_compare;
            rsp_second_ff <= rd_second_ff[bit_pos] ? cfg.one_compare : cfg.zero_compare;
            rsp_third_ff  <= rd_third_ff[bit_pos] ? cfg.one_compare : cfg.zero_compare;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_period         = rsp_period_ff;
   assign rsp_compare_first  = rsp_first_ff;
   assign rsp_compare_second = rsp_second_ff;
   assign rsp_compare_third  = rsp_third_ff;
   assign rsp_reset_slot     = rsp_reset_ff;

   a_no_pop_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clear_busy_ff |-> !pop)
      else $error("queue popped during clearing pass");

   a_led_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      led_cnt_ff <= FRAME_END)
      else $error("led counter past frame end");

   a_bit_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      bit_cnt_ff <= ws2812s_pkg::LAST_BIT)
      else $error("bit counter past last color bit");

   a_frame_end_bit_zero: assert property (@(posedge clock) disable iff (reset)
      end_of_frame |-> bit_cnt_ff == '0)
      else $error("frame end reached mid color word");

   a_read_data_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(rd_first_ff)
         && $stable(rd_second_ff) && $stable(rd_third_ff) && $stable(s1_bit_ff))
      else $error("read stage lost data while held");

endmodule

// ===== hdl/three_channel_ws2812_bit_serializer_unit.sv =====
// three channel ws2812 bit-slot serializer
//
// req channel: kind selects a color write (led_index, color) or a bit-slot tick.
// writes are routed to a channel by the two start registers and stored; writes
// whose offset falls past the channel depth are dropped. writes give no rsp word.
// rsp channel: one word per tick with the pwm period and three compare values,
// msb first through each led's 24 bits, then one reset slot after the last led.
// csr port: write enable, index and data; write only while the block is idle.
// throughput: one req word per cycle, writes and ticks alike, while req_stall
// is low. a tick's rsp word passes the queue, the store read stage and the
// rsp register before it is valid.
// the four-entry queue between routing and store access keeps req flowing while
// rsp is stalled; once the queue fills, req_stall rises.
// reset: config returns to its defaults, counters clear, and the frame store is
// swept to zero row by row, during which req_stall is high.
module three_channel_ws2812_bit_serializer_unit #(
   parameter int LEDS_PER_CHANNEL = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_kind,
   input  logic [ws2812s_pkg::INDEX_W-1:0]         req_led_index,
   input  logic [ws2812s_pkg::COLOR_W-1:0]         req_color,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [ws2812s_pkg::WORD_W-1:0]          rsp_period,
   output logic [ws2812s_pkg::WORD_W-1:0]          rsp_compare_first,
   output logic [ws2812s_pkg::WORD_W-1:0]          rsp_compare_second,
   output logic [ws2812s_pkg::WORD_W-1:0]          rsp_compare_third,
   output logic                                    rsp_reset_slot,
   input  logic                                    csr_write_enable,
   input  logic [ws2812s_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ws2812s_pkg::WORD_W-1:0]          csr_wdata
);

   ws2812s_pkg::cfg_type  cfg_ff, cfg_in;
   ws2812s_pkg::word_type push_word;
   ws2812s_pkg::head_type head;
   logic                  push, pop, queue_full, clearing;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            ws2812s_pkg::CSR_SECOND_START:
               cfg_in.second_start = csr_wdata[ws2812s_pkg::INDEX_W-1:0];
            ws2812s_pkg::CSR_THIRD_START:
               cfg_in.third_start = csr_wdata[ws2812s_pkg::INDEX_W-1:0];
            ws2812s_pkg::CSR_BIT_PERIOD:   cfg_in.bit_period   = csr_wdata;
            ws2812s_pkg::CSR_RESET_PERIOD: cfg_in.reset_period = csr_wdata;
            ws2812s_pkg::CSR_ZERO_COMPARE: cfg_in.zero_compare = csr_wdata;
            ws2812s_pkg::CSR_ONE_COMPARE:  cfg_in.one_compare  = csr_wdata;
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.second_start <= ws2812s_pkg::RST_SECOND_START;
         cfg_ff.third_start  <= ws2812s_pkg::RST_THIRD_START;
         cfg_ff.bit_period   <= ws2812s_pkg::RST_BIT_PERIOD;
         cfg_ff.reset_period <= ws2812s_pkg::RST_RESET_PERIOD;
         cfg_ff.zero_compare <= ws2812s_pkg::RST_ZERO_COMPARE;
         cfg_ff.one_compare  <= ws2812s_pkg::RST_ONE_COMPARE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ws2812s_front #(
      .LEDS_PER_CHANNEL(LEDS_PER_CHANNEL)
   ) u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_led_index (req_led_index),
      .req_color     (req_color),
      .cfg           (cfg_ff),
      .queue_full    (queue_full),
      .clearing      (clearing),
      .push          (push),
      .push_word     (push_word)
   );

   ws2812s_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (queue_full),
      .head      (head),
      .pop       (pop)
   );

   ws2812s_back #(
      .LEDS_PER_CHANNEL(LEDS_PER_CHANNEL)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .head               (head),
      .pop                (pop),
      .clearing           (clearing),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_period         (rsp_period),
      .rsp_compare_first  (rsp_compare_first),
      .rsp_compare_second (rsp_compare_second),
      .rsp_compare_third  (rsp_compare_third),
      .rsp_reset_slot     (rsp_reset_slot)
   );

endmodule

// ===== tb/tb_three_channel_ws2812_bit_serializer_unit.sv =====
`timescale 1ns / 1ps

module tb_three_channel_ws2812_bit_serializer_unit;

   localparam int LEDS          = 32;
   localparam int SETTLE_CYCLES = 12;
   localparam int QUIET_LIMIT   = 3000;
   localparam int HOLD_CYCLES   = 64;
   localparam int PHASE_WORDS   = 125;
   localparam int PHASES        = 5;

   localparam int WORD_W      = ws2812s_pkg::WORD_W;
   localparam int COLOR_W     = ws2812s_pkg::COLOR_W;
   localparam int INDEX_W     = ws2812s_pkg::INDEX_W;
   localparam int CSR_INDEX_W = ws2812s_pkg::CSR_INDEX_W;

   typedef struct packed {
      logic [WORD_W-1:0] period;
      logic [WORD_W-1:0] first;
      logic [WORD_W-1:0] second;
      logic [WORD_W-1:0] third;
      logic              reset_slot;
   } slot_type;

   // tracks the frame store and slot position, queues the pwm slots due
   class slot_scoreboard;
      logic [COLOR_W-1:0]   frame [3][LEDS];
      int unsigned          led_pos;
      int unsigned          bit_pos;
      ws2812s_pkg::cfg_type cfg;
      slot_type             slots_due[$];
      int                   fail_count;

      function new();
         foreach (frame[c, i]) frame[c][i] = '0;
         led_pos               = 0;
         bit_pos               = 0;
         cfg.second_start      = ws2812s_pkg::RST_SECOND_START;
         cfg.third_start       = ws2812s_pkg::RST_THIRD_START;
         cfg.bit_period        = ws2812s_pkg::RST_BIT_PERIOD;
         cfg.reset_period      = ws2812s_pkg::RST_RESET_PERIOD;
         cfg.zero_compare      = ws2812s_pkg::RST_ZERO_COMPARE;
         cfg.one_compare       = ws2812s_pkg::RST_ONE_COMPARE;
         fail_count            = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [WORD_W-1:0] data);
         case (idx)
            ws2812s_pkg::CSR_SECOND_START: cfg.second_start = data[INDEX_W-1:0];
            ws2812s_pkg::CSR_THIRD_START:  cfg.third_start  = data[INDEX_W-1:0];
            ws2812s_pkg::CSR_BIT_PERIOD:   cfg.bit_period   = data;
            ws2812s_pkg::CSR_RESET_PERIOD: cfg.reset_period = data;
            ws2812s_pkg::CSR_ZERO_COMPARE: cfg.zero_compare = data;
            ws2812s_pkg::CSR_ONE_COMPARE:  cfg.one_compare  = data;
            default: ;
         endcase
      endfunction

      function logic [WORD_W-1:0] bit_code(logic [COLOR_W-1:0] color);
         return color[COLOR_W-1-bit_pos] ? cfg.one_compare : cfg.zero_compare;
      endfunction

      function void note_word(ws2812s_pkg::kind_type kind, logic [INDEX_W-1:0] idx,
                              logic [COLOR_W-1:0] color);
         ws2812s_pkg::chan_type ch;
         logic [INDEX_W-1:0]    offset;
         slot_type              s;
         if (kind == ws2812s_pkg::KIND_WRITE) begin
            // boundaries tested in order, so the offset never wraps negative
            if (idx < cfg.second_start) begin
               ch     = ws2812s_pkg::CH_FIRST;
               offset = idx;
            end else if (idx < cfg.third_start) begin
               ch     = ws2812s_pkg::CH_SECOND;
               offset = idx - cfg.second_start;
            end else begin
               ch     = ws2812s_pkg::CH_THIRD;
               offset = idx - cfg.third_start;
            end
            if (offset < LEDS) frame[int'(ch)][offset] = color;
         end else begin
            if (led_pos >= LEDS) begin
               // end of frame: reset slot, then restart
               led_pos      = 0;
               bit_pos      = 0;
               s.period     = cfg.reset_period;
               s.first      = '0;
               s.second     = '0;
               s.third      = '0;
               s.reset_slot = 1'b1;
            end else begin
               s.period     = cfg.bit_period;
               s.first      = bit_code(frame[0][led_pos]);
               s.second     = bit_code(frame[1][led_pos]);
               s.third      = bit_code(frame[2][led_pos]);
               s.reset_slot = 1'b0;
               bit_pos++;
               if (bit_pos >= COLOR_W) begin
                  bit_pos = 0;
                  led_pos++;
               end
            end
            slots_due.push_back(s);
         end
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         fail_count++;
      endtask

      task check_slot(slot_type got);
         slot_type want;
         if (slots_due.size() == 0) begin
            report($sformatf("slot with nothing due, period %0d", got.period));
         end else begin
            want = slots_due.pop_front();
            if (got.period !== want.period)
               report($sformatf("period got %0d want %0d", got.period, want.period));
            if (got.first !== want.first)
               report($sformatf("compare_first got %0d want %0d", got.first, want.first));
            if (got.second !== want.second)
               report($sformatf("compare_second got %0d want %0d", got.second, want.second));
            if (got.third !== want.third)
               report($sformatf("compare_third got %0d want %0d", got.third, want.third));
            if (got.reset_slot !== want.reset_slot)
               report($sformatf("reset_slot got %0b want %0b",
                                got.reset_slot, want.reset_slot));
         end
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_kind;
   logic [INDEX_W-1:0]     req_led_index;
   logic [COLOR_W-1:0]     req_color;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [WORD_W-1:0]      rsp_period;
   logic [WORD_W-1:0]      rsp_compare_first;
   logic [WORD_W-1:0]      rsp_compare_second;
   logic [WORD_W-1:0]      rsp_compare_third;
   logic                   rsp_reset_slot;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [WORD_W-1:0]      csr_wdata;

   slot_scoreboard board = new();
   bit                     steady = 1'b0;
   bit                     hold_request = 1'b0;
   int                     quiet_cycles = 0;

   three_channel_ws2812_bit_serializer_unit #(.LEDS_PER_CHANNEL(LEDS)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_led_index      (req_led_index),
      .req_color          (req_color),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_period         (rsp_period),
      .rsp_compare_first  (rsp_compare_first),
      .rsp_compare_second (rsp_compare_second),
      .rsp_compare_third  (rsp_compare_third),
      .rsp_reset_slot     (rsp_reset_slot),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #4 clock = ~clock;

   task automatic send_word(ws2812s_pkg::kind_type kind, logic [INDEX_W-1:0] idx,
                            logic [COLOR_W-1:0] color);
      while (!steady && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_led_index <= idx;
      req_color     <= color;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_word(kind, idx, color);
   endtask

   task automatic send_random_word();
      ws2812s_pkg::kind_type kind;
      logic [INDEX_W-1:0]    idx;
      logic [COLOR_W-1:0]    color;
      int unsigned           pick;
      kind  = ($urandom_range(99) < 80) ? ws2812s_pkg::KIND_TICK : ws2812s_pkg::KIND_WRITE;
      color = COLOR_W'($urandom);
      pick  = $urandom_range(15);
      if (pick == 0) color = '0;
      else if (pick == 1) color = '1;
      // aim writes at the channel boundaries and at the end of each channel
      case ($urandom_range(9))
         0: idx = INDEX_W'(board.cfg.second_start + $urandom_range(4) - 2);
         1: idx = INDEX_W'(board.cfg.third_start + $urandom_range(4) - 2);
         2: idx = INDEX_W'(board.cfg.second_start + 30 + $urandom_range(3));
         3: idx = INDEX_W'(board.cfg.third_start + 30 + $urandom_range(3));
         default: idx = INDEX_W'($urandom_range(127));
      endcase
      send_word(kind, idx, color);
   endtask

   task automatic program_regs(logic [WORD_W-1:0] second, logic [WORD_W-1:0] third,
                               logic [WORD_W-1:0] bper, logic [WORD_W-1:0] rper,
                               logic [WORD_W-1:0] zc, logic [WORD_W-1:0] oc);
      logic [CSR_INDEX_W-1:0] which [6];
      logic [WORD_W-1:0]      value [6];
      which = '{ws2812s_pkg::CSR_SECOND_START, ws2812s_pkg::CSR_THIRD_START,
                ws2812s_pkg::CSR_BIT_PERIOD, ws2812s_pkg::CSR_RESET_PERIOD,
                ws2812s_pkg::CSR_ZERO_COMPARE, ws2812s_pkg::CSR_ONE_COMPARE};
      value = '{second, third, bper, rper, zc, oc};
      for (int k = 0; k < 6; k++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= which[k];
         csr_wdata        <= value[k];
         @(posedge clock);
         board.set_reg(which[k], value[k]);
      end
      csr_write_enable <= 1'b0;
   endtask

   task automatic wait_drained();
      while (board.slots_due.size() != 0) @(posedge clock);
      // writes, which give no slot, may still sit in the queue
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result side: random stalls plus one long hold-off on request
   initial begin
      slot_type got;
      int       hold_left;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            got.period     = rsp_period;
            got.first      = rsp_compare_first;
            got.second     = rsp_compare_second;
            got.third      = rsp_compare_third;
            got.reset_slot = rsp_reset_slot;
            board.check_slot(got);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            rsp_stall   <= 1'b1;
         end else begin
            rsp_stall <= !steady && ($urandom_range(99) < 22);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_kind         <= ws2812s_pkg::KIND_WRITE;
      req_led_index    <= '0;
      req_color        <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= ws2812s_pkg::CSR_SECOND_START;
      csr_wdata        <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: first and last led of each channel, dropped writes, ticks
      send_word(ws2812s_pkg::KIND_WRITE, 7'd0,   24'hFFFFFF);
      send_word(ws2812s_pkg::KIND_WRITE, 7'd27,  24'hAAAAAA);
      send_word(ws2812s_pkg::KIND_WRITE, 7'd55,  24'h800001);
      send_word(ws2812s_pkg::KIND_WRITE, 7'd26,  24'h00FF00);
      send_word(ws2812s_pkg::KIND_WRITE, 7'd54,  24'h0F0F0F);
      send_word(ws2812s_pkg::KIND_WRITE, 7'd86,  24'h123456);
      send_word(ws2812s_pkg::KIND_WRITE, 7'd87,  24'hFFFFFF);
      send_word(ws2812s_pkg::KIND_WRITE, 7'd127, 24'h5A5A5A);
      send_word(ws2812s_pkg::KIND_TICK,  7'd127, 24'hFFFFFF);
      for (int k = 0; k < 7; k++) send_word(ws2812s_pkg::KIND_TICK, 7'd0, 24'h000000);
      // rewrite the led being sent, mid-word
      send_word(ws2812s_pkg::KIND_WRITE, 7'd0,   24'h000000);
      send_word(ws2812s_pkg::KIND_WRITE, 7'd27,  24'h555555);
      for (int k = 0; k < 8; k++)
         send_word(ws2812s_pkg::KIND_TICK, INDEX_W'(k * 17), 24'hC3C3C3);

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            req_valid <= 1'b0;
            wait_drained();
            case (p)
               1: program_regs(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
               2: program_regs(16'd127, 16'd127, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
               3: program_regs(16'd40, 16'd10, WORD_W'($urandom), WORD_W'($urandom),
                               WORD_W'($urandom), WORD_W'($urandom));
               default: program_regs(16'd32, 16'd64, WORD_W'($urandom), WORD_W'($urandom),
                                     WORD_W'($urandom), WORD_W'($urandom));
            endcase
         end
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if ((p == 0 || p == 3) && n == 40) hold_request = 1'b1;
            if (p == 2) steady = (n >= 20 && n < 100);
            send_random_word();
         end
         steady = 1'b0;
      end

      req_valid <= 1'b0;
      wait_drained();
      if (board.fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
